>>> src/nlps_pkg.sv
// Shared types and constants for the nearest location point search block.
// Holds table sizing, field widths, command and status codes and the
// structs passed between the sequencer, the point RAM and the distance unit.
`default_nettype none

package nlps_pkg;

   // Table sizing and coordinate width
   localparam int TABLE_DEPTH = 256;
   localparam int COORD_BITS  = 18;

   localparam int IDX_BITS  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);
   localparam int MAG_BITS  = COORD_BITS + 1;
   localparam int DIST_BITS = 2 * COORD_BITS + 2;

   // Fixed widths of the result fields
   localparam int STATUS_FIELD_BITS = 2;
   localparam int INDEX_FIELD_BITS  = 8;
   localparam int DIST_FIELD_BITS   = 38;
   localparam int COUNT_FIELD_BITS  = 9;
   localparam int CMD_FIELD_BITS    = 2;

   // Stream data widths, padded to whole bytes
   localparam int REQ_DATA_BITS = ((3 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS =
      ((INDEX_FIELD_BITS + DIST_FIELD_BITS + COUNT_FIELD_BITS + 7) / 8) * 8;

   typedef enum logic [CMD_FIELD_BITS-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_FIELD_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [IDX_BITS-1:0]          idx_type;
   typedef logic [CNT_BITS-1:0]          cnt_type;
   typedef logic [DIST_BITS-1:0]         dist_type;

   typedef struct packed {
      coord_type z;
      coord_type y;
      coord_type x;
   } point_type;

   // One axis step handed to the distance unit
   typedef struct packed {
      logic    valid;
      logic    first;
      logic    last;
      logic    closing;
      idx_type idx;
   } feed_type;

   // Marks that the squared distance of one entry is finished
   typedef struct packed {
      logic    valid;
      logic    closing;
      idx_type idx;
   } dout_type;

   typedef struct packed {
      status_type                  status;
      logic [INDEX_FIELD_BITS-1:0] index;
      logic [DIST_FIELD_BITS-1:0]  distance;
      logic [COUNT_FIELD_BITS-1:0] count;
   } res_type;

endpackage

`default_nettype wire

>>> src/nlps_point_ram.sv
// Point table storage: one write port and one registered read port.
// Depends on nlps_pkg for the table depth and point layout.
`default_nettype none

module nlps_point_ram (
   input  wire                 clock,
   input  wire                 wr_en,
   input  nlps_pkg::idx_type   wr_addr,
   input  nlps_pkg::point_type wr_data,
   input  wire                 rd_en,
   input  nlps_pkg::idx_type   rd_addr,
   output nlps_pkg::point_type rd_data
);
   import nlps_pkg::*;

   point_type mem_ff [TABLE_DEPTH];
   point_type rd_data_ff;

   // Write the new point, register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/nlps_dist_unit.sv
// Shared subtract, square and accumulate unit, one axis per cycle.
// Three register stages: magnitude of difference, square, running sum.
// Depends on nlps_pkg for widths and the feed and result structs.
`default_nettype none

module nlps_dist_unit (
   input  wire                 clock,
   input  wire                 reset,
   input  nlps_pkg::feed_type  feed,
   input  nlps_pkg::coord_type q_coord,
   input  nlps_pkg::coord_type t_coord,
   output nlps_pkg::dout_type  dout,
   output nlps_pkg::dist_type  acc_dist
);
   import nlps_pkg::*;

   logic signed [COORD_BITS:0] diff;
   logic [MAG_BITS-1:0]        mag_in;
   logic [MAG_BITS-1:0]        mag_ff;
   feed_type                   s1_ff;
   dist_type                   sq_in;
   dist_type                   sq_ff;
   feed_type                   s2_ff;
   dist_type                   acc_in;
   dist_type                   acc_ff;
   dout_type                   dout_in;
   dout_type                   dout_ff;

   // Difference magnitude of one axis
   always_comb begin
      diff   = {q_coord[COORD_BITS-1], q_coord} - {t_coord[COORD_BITS-1], t_coord};
      mag_in = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
   end

   // Square and accumulate; the last axis closes the entry
   always_comb begin
      sq_in         = DIST_BITS'(mag_ff) * DIST_BITS'(mag_ff);
      acc_in        = (s2_ff.first ? '0 : acc_ff) + sq_ff;
      dout_in.valid   = s2_ff.valid && s2_ff.last;
      dout_in.closing = s2_ff.closing;
      dout_in.idx     = s2_ff.idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid   <= 1'b0;
         s2_ff.valid   <= 1'b0;
         dout_ff.valid <= 1'b0;
      end else begin
         s1_ff   <= feed;
         s2_ff   <= s1_ff;
         dout_ff <= dout_in;
         if (s2_ff.valid) begin
            acc_ff <= acc_in;
         end
      end
      mag_ff <= mag_in;
      sq_ff  <= sq_in;
   end

   assign dout     = dout_ff;
   assign acc_dist = acc_ff;

endmodule

`default_nettype wire

>>> src/nearest_location_point_search.sv
// Top level of the nearest location point search block: command decode,
// scan sequencer, nearest-entry tracking and the result register.
// Depends on nlps_pkg, nlps_point_ram and nlps_dist_unit.
`default_nettype none

// Keeps up to TABLE_DEPTH points (signed eighths of a unit) in a RAM and
// answers clear, add and query commands with one result item each. Clear and
// add results go through the pending register and then the output register.
// A query on a table of N points scans every entry before its result: one
// subtract-square-accumulate unit handles one axis of one entry per cycle,
// with the next RAM word read during the last axis of the current entry.
// While a query scans, req_tready is low. A new item is taken as soon as the
// block is idle, even while the previous result still waits in the output
// register. Distances are in squared eighths; ties go to the earliest entry.
// No clearing pass runs after reset: entries are read only below the count.
module nearest_location_point_search (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // coord_x, coord_y, coord_z from the lowest bit up, zero padded
   input  wire  [nlps_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // command
   input  wire  [nlps_pkg::CMD_FIELD_BITS-1:0]   req_tuser,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // entry_index, nearest_distance_sq, entry_count from the lowest bit up
   output logic [nlps_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // status
   output logic [nlps_pkg::STATUS_FIELD_BITS-1:0] rsp_tuser
);
   import nlps_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_POST
   } state_type;

   state_type state_ff, state_in;
   cnt_type   count_ff, count_in;
   cnt_type   ent_ff, ent_in;
   cnt_type   ent_plus;
   axis_type  axis_ff, axis_in;
   point_type q_ff, q_in;
   res_type   pend_ff, pend_in;
   res_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   dist_type  best_ff, best_in;
   idx_type   best_idx_ff, best_idx_in;

   logic      accept;
   cmd_type   cmd;
   point_type req_point;
   logic      wr_en;
   idx_type   wr_addr;
   logic      rd_en;
   idx_type   rd_addr;
   point_type rd_data;
   feed_type  feed;
   coord_type q_coord;
   coord_type t_coord;
   dout_type  dout;
   dist_type  entry_dist;
   logic      take;

   nlps_point_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_point),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nlps_dist_unit u_dist (
      .clock    (clock),
      .reset    (reset),
      .feed     (feed),
      .q_coord  (q_coord),
      .t_coord  (t_coord),
      .dout     (dout),
      .acc_dist (entry_dist)
   );

   // Unpack the request item
   assign req_tready  = (state_ff == S_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign cmd         = cmd_type'(req_tuser);
   assign req_point.x = req_tdata[COORD_BITS-1:0];
   assign req_point.y = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign req_point.z = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign ent_plus    = ent_ff + 1'b1;

   function automatic cnt_type ent_plus_of(input cnt_type value);
      ent_plus_of = value + 1'b1;
   endfunction

   // Select the axis under work for both points
   always_comb begin
      unique case (axis_ff)
         AXIS_X: begin
            q_coord = q_ff.x;
            t_coord = rd_data.x;
         end
         AXIS_Y: begin
            q_coord = q_ff.y;
            t_coord = rd_data.y;
         end
         AXIS_Z: begin
            q_coord = q_ff.z;
            t_coord = rd_data.z;
         end
         default: begin
            q_coord = q_ff.x;
            t_coord = rd_data.x;
         end
      endcase
   end

   // Track the nearest entry; only a strictly smaller distance replaces it
   always_comb begin
      take        = dout.valid && ((dout.idx == '0) || (entry_dist < best_ff));
      best_in     = take ? entry_dist : best_ff;
      best_idx_in = take ? dout.idx : best_idx_ff;
   end

   // Sequencer, table count and result register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ent_in       = ent_ff;
      axis_in      = axis_ff;
      q_in         = q_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_BITS-1:0];
      rd_en        = 1'b0;
      rd_addr      = '0;
      feed         = '0;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pend_in = '{ST_OK, '0, '0, COUNT_FIELD_BITS'(count_ff)};
               state_in = S_POST;
               unique case (cmd)
                  CMD_CLEAR: begin
                     count_in      = '0;
                     pend_in.count = '0;
                  end
                  CMD_ADD: begin
                     if (count_ff == CNT_BITS'(TABLE_DEPTH)) begin
                        pend_in.status = ST_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        count_in      = ent_plus_of(count_ff);
                        pend_in.index = INDEX_FIELD_BITS'(count_ff);
                        pend_in.count = COUNT_FIELD_BITS'(ent_plus_of(count_ff));
                     end
                  end
                  CMD_QUERY: begin
                     if (count_ff == '0) begin
                        pend_in.status = ST_EMPTY;
                     end else begin
                        q_in     = req_point;
                        ent_in   = '0;
                        axis_in  = AXIS_X;
                        rd_en    = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            feed.valid   = 1'b1;
            feed.first   = (axis_ff == AXIS_X);
            feed.last    = (axis_ff == AXIS_Z);
            feed.closing = (axis_ff == AXIS_Z) && (ent_plus == count_ff);
            feed.idx     = ent_ff[IDX_BITS-1:0];
            unique case (axis_ff)
               AXIS_X: axis_in = AXIS_Y;
               AXIS_Y: axis_in = AXIS_Z;
               AXIS_Z: begin
                  // Fetch the next entry during the last axis
                  axis_in = AXIS_X;
                  rd_en   = 1'b1;
                  rd_addr = ent_plus[IDX_BITS-1:0];
                  ent_in  = ent_plus;
                  if (ent_plus == count_ff) begin
                     state_in = S_DRAIN;
                  end
               end
               default: axis_in = AXIS_X;
            endcase
         end
         S_DRAIN: begin
            if (dout.valid && dout.closing) begin
               pend_in = '{ST_OK, INDEX_FIELD_BITS'(best_idx_in),
                           DIST_FIELD_BITS'(best_in), COUNT_FIELD_BITS'(count_ff)};
               state_in = S_POST;
            end
         end
         S_POST: begin
            // Hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ent_ff      <= ent_in;
      axis_ff     <= axis_in;
      q_ff        <= q_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   // Drive the result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_ff.count, rsp_ff.distance, rsp_ff.index});

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(TABLE_DEPTH))
      else $error("point count beyond table depth");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (ent_ff < count_ff))
      else $error("scan entry at or beyond point count");

   a_dist_only_in_query: assert property (@(posedge clock) disable iff (reset)
      dout.valid |-> ((state_ff == S_SCAN) || (state_ff == S_DRAIN)))
      else $error("distance result outside a query scan");

   a_post_delivers: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_POST) && (!rsp_valid_ff || rsp_tready))
      |=> (rsp_tvalid && (state_ff == S_IDLE)))
      else $error("pending result not handed to the output register");

   a_table_stable_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |=> $stable(count_ff))
      else $error("point count changed during a scan");
`endif

endmodule

`default_nettype wire
